// File: rtl/core/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared widths, types and helpers for the tetrahedron gradient block.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int CW        = 32;             // coordinate and gradient width
    localparam int FRAC_BITS = 16;             // fraction bits of the Q format
    localparam int NCRD      = 12;             // coordinates per element
    localparam int IN_W      = NCRD * CW;
    localparam int JW        = CW + 1;         // jacobian entry
    localparam int PW        = 2 * JW;         // cofactor product
    localparam int AW        = PW + 1;         // adjugate entry
    localparam int LOW       = 34;             // low slice of adjugate for det products
    localparam int HIW       = AW - LOW;
    localparam int PLW       = JW + LOW + 1;
    localparam int PHW       = JW + HIW;
    localparam int TW        = PHW + LOW + 1;  // one det term
    localparam int DW        = TW + 2;         // determinant
    localparam int DMW       = DW;             // divisor magnitude
    localparam int NMW       = AW + 2 * FRAC_BITS; // dividend magnitude and quotient
    localparam int QSW       = NMW + 1;        // signed quotient
    localparam int SW        = NMW + 3;        // sum of three quotients
    localparam int SATW      = NMW + 4;
    localparam int AXW       = 2;
    localparam logic [AXW-1:0] LAST_ROW = AXW'(2);
    localparam logic [CW-1:0]  SAT_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]  SAT_MIN  = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [2:0][2:0][AW-1:0] adj;
        logic [DW-1:0]           det;
    } t_elem;

    typedef struct packed {
        logic [AXW-1:0] axis;
        logic           last;
        logic           degen;
        logic [2:0]     neg;
    } t_tag;

    function automatic logic [CW-1:0] sat32(input logic [SATW-1:0] v);
        logic [CW-1:0] res;
        if (v[SATW-1]) begin
            res = (&v[SATW-1:CW-1]) ? v[CW-1:0] : SAT_MIN;
        end else begin
            res = (~|v[SATW-1:CW-1]) ? v[CW-1:0] : SAT_MAX;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/tsg_front.sv
// ----------------------------------------------------------------------------
// tsg_front
// Six-stage pipeline: jacobian, cofactor products, adjugate, determinant.
// ----------------------------------------------------------------------------
module tsg_front import tsg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output t_elem           o_elem
);

    logic [6:1] r_v;
    logic [6:1] en;

    logic signed [JW-1:0]  r_jm   [3][3];
    logic signed [PW-1:0]  r_pa   [3][3];
    logic signed [PW-1:0]  r_pb   [3][3];
    logic signed [JW-1:0]  r_jm2  [3];
    logic signed [AW-1:0]  r_adj3 [3][3];
    logic signed [JW-1:0]  r_jm3  [3];
    logic signed [PLW-1:0] r_pl   [3];
    logic signed [PHW-1:0] r_ph   [3];
    logic signed [AW-1:0]  r_adj4 [3][3];
    logic signed [TW-1:0]  r_t    [3];
    logic signed [AW-1:0]  r_adj5 [3][3];
    logic signed [DW-1:0]  r_det;
    logic signed [AW-1:0]  r_adj6 [3][3];

    always_comb begin
        en[6] = !r_v[6] || i_ready;
        for (int s = 5; s >= 1; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end
    assign o_ready = en[1];
    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_valid;
            for (int s = 2; s <= 6; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // stage 1: edge vectors relative to the fourth corner
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_jm[i][j] <= JW'($signed(i_data[(i*3+j)*CW +: CW]))
                                - JW'($signed(i_data[(9+j)*CW +: CW]));
                end
            end
        end
    end

    // stage 2: cofactor products
    for (genvar gj = 0; gj < 3; gj++) begin : g_row
        for (genvar gk = 0; gk < 3; gk++) begin : g_col
            localparam int R1 = (gk + 1) % 3;
            localparam int R2 = (gk + 2) % 3;
            localparam int C1 = (gj + 1) % 3;
            localparam int C2 = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (en[2]) begin
                    r_pa[gj][gk] <= r_jm[R1][C1] * r_jm[R2][C2];
                    r_pb[gj][gk] <= r_jm[R1][C2] * r_jm[R2][C1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int j = 0; j < 3; j++) r_jm2[j] <= r_jm[0][j];
        end
        // stage 3: adjugate
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                r_jm3[j] <= r_jm2[j];
                for (int k = 0; k < 3; k++) begin
                    r_adj3[j][k] <= AW'(r_pa[j][k]) - AW'(r_pb[j][k]);
                end
            end
        end
        // stage 4: determinant partial products, adjugate split in two slices
        if (en[4]) begin
            r_adj4 <= r_adj3;
            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= r_jm3[j] * $signed({1'b0, r_adj3[j][0][LOW-1:0]});
                r_ph[j] <= r_jm3[j] * $signed(r_adj3[j][0][AW-1:LOW]);
            end
        end
        if (en[5]) begin
            r_adj5 <= r_adj4;
            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (TW'(r_ph[j]) <<< LOW) + TW'(r_pl[j]);
            end
        end
        if (en[6]) begin
            r_adj6 <= r_adj5;
            r_det  <= DW'(r_t[0]) + DW'(r_t[1]) + DW'(r_t[2]);
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                o_elem.adj[j][k] = r_adj6[j][k];
            end
        end
        o_elem.det = r_det;
    end

endmodule

// File: rtl/core/tsg_rowseq.sv
// ----------------------------------------------------------------------------
// tsg_rowseq
// Holds one element and issues its three gradient rows, one per cycle while i_en is high.
// ----------------------------------------------------------------------------
module tsg_rowseq import tsg_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_elem          i_elem,
    input  logic           i_en,
    output logic           o_valid,
    output logic [NMW-1:0] o_num [3],
    output logic [DMW-1:0] o_den,
    output t_tag           o_tag
);

    logic                 r_busy;
    logic [AXW-1:0]       r_row;
    logic signed [AW-1:0] r_adj [3][3];
    logic [DMW-1:0]       r_dmag;
    logic                 r_dneg;
    logic                 r_degen;
    logic signed [DW-1:0] det_s;
    logic signed [AW-1:0] cur;
    logic [AW-1:0]        amag;

    assign o_ready = !r_busy || (i_en && r_row == LAST_ROW);
    assign o_valid = r_busy;
    assign det_s   = $signed(i_elem.det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_row  <= '0;
        end else if (i_en) begin
            r_row <= r_row + AXW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_adj[j][k] <= $signed(i_elem.adj[j][k]);
                end
            end
            r_dmag  <= det_s[DW-1] ? DMW'(-det_s) : DMW'(det_s);
            r_dneg  <= det_s[DW-1];
            r_degen <= (det_s == '0);
        end
    end

    always_comb begin
        o_tag.axis  = r_row;
        o_tag.last  = (r_row == LAST_ROW);
        o_tag.degen = r_degen;
        o_den       = r_dmag;
        for (int k = 0; k < 3; k++) begin
            cur          = r_adj[r_row][k];
            amag         = cur[AW-1] ? AW'(-cur) : AW'(cur);
            o_num[k]     = NMW'(amag) << (2 * FRAC_BITS);
            o_tag.neg[k] = cur[AW-1] ^ r_dneg;
        end
    end

endmodule

// File: rtl/core/tsg_div.sv
// ----------------------------------------------------------------------------
// tsg_div
// Three-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module tsg_div import tsg_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NMW-1:0] i_num [3],
    input  logic [DMW-1:0] i_den,
    input  t_tag           i_tag,
    output logic           o_valid,
    output logic [NMW-1:0] o_quo [3],
    output t_tag           o_tag
);

    logic [NMW:0]     r_v;
    logic [NMW-1:0]   r_num [0:NMW][3];   // dividend bits shift out, quotient bits in
    logic [DMW-1:0]   r_rem [0:NMW-1][3];
    logic [DMW-1:0]   r_den [0:NMW-1];
    t_tag             r_tag [0:NMW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NMW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_den[0] <= i_den;
            for (int l = 0; l < 3; l++) begin
                r_num[0][l] <= i_num[l];
                r_rem[0][l] <= '0;
            end
        end
    end

    for (genvar gs = 0; gs < NMW; gs++) begin : g_stage
        logic [DMW:0]   t    [3];
        logic [DMW:0]   diff [3];
        logic           ge   [3];
        logic [DMW-1:0] nrem [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                t[l]    = {r_rem[gs][l], r_num[gs][l][NMW-1]};
                diff[l] = t[l] - {1'b0, r_den[gs]};
                ge[l]   = (t[l] >= {1'b0, r_den[gs]});
                nrem[l] = ge[l] ? diff[l][DMW-1:0] : t[l][DMW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[gs+1] <= r_tag[gs];
                for (int l = 0; l < 3; l++) begin
                    r_num[gs+1][l] <= {r_num[gs][l][NMW-2:0], ge[l]};
                end
            end
        end

        if (gs < NMW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[gs+1] <= r_den[gs];
                    for (int l = 0; l < 3; l++) begin
                        r_rem[gs+1][l] <= nrem[l];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[NMW];
    assign o_tag   = r_tag[NMW];
    always_comb begin
        for (int l = 0; l < 3; l++) o_quo[l] = r_num[NMW][l];
    end

endmodule

// File: rtl/core/tsg_post.sv
// ----------------------------------------------------------------------------
// tsg_post
// Quotient signs, fourth gradient, saturation and the output register.
// ----------------------------------------------------------------------------
module tsg_post import tsg_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NMW-1:0] i_quo [3],
    input  t_tag           i_tag,
    output logic           o_valid,
    output logic [CW-1:0]  o_grad [4],
    output t_tag           o_tag
);

    logic [3:1]           r_v;
    logic signed [QSW-1:0] r_q [3];
    t_tag                 r_tag1;
    logic signed [SW-1:0] r_sum;
    logic [CW-1:0]        r_g2 [3];
    t_tag                 r_tag2;
    logic [CW-1:0]        r_g3 [4];
    t_tag                 r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag1 <= i_tag;
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= i_tag.neg[k] ? -$signed({1'b0, i_quo[k]})
                                       : $signed({1'b0, i_quo[k]});
            end
            r_tag2 <= r_tag1;
            r_sum  <= SW'(r_q[0]) + SW'(r_q[1]) + SW'(r_q[2]);
            for (int k = 0; k < 3; k++) begin
                r_g2[k] <= r_tag1.degen ? '0 : sat32(SATW'(r_q[k]));
            end
            r_tag3 <= r_tag2;
            for (int k = 0; k < 3; k++) r_g3[k] <= r_g2[k];
            r_g3[3] <= r_tag2.degen ? '0 : sat32(-SATW'(r_sum));
        end
    end

    assign o_valid = r_v[3];
    assign o_tag   = r_tag3;
    always_comb begin
        for (int k = 0; k < 4; k++) o_grad[k] = r_g3[k];
    end

endmodule

// File: rtl/core/tet_shape_gradient.sv
// ----------------------------------------------------------------------------
// tet_shape_gradient
// Shape-function gradients of a linear tetrahedron in signed Q16.16.
// ----------------------------------------------------------------------------
// One element (four corners) is taken per input beat and gives three output
// beats, one per axis x, y, z, the last with tlast set. A new element is
// taken as the last row of the previous one issues: the three rows of an
// element share one set of three pipelined dividers that take one row per
// cycle while the output is not stalled. Most of the delay to the first output
// beat is the 99-stage bit-per-stage divider. A zero determinant flags tuser[2]
// and zeroes the gradients; out-of-range gradients saturate. Back-pressure on
// the output stalls the divider and post stages together without losing beats.
module tet_shape_gradient import tsg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // grad_a, grad_b, grad_c, grad_d
    output logic [4*CW-1:0] m_axis_tdata,
    // axis[1:0], degenerate
    output logic [2:0]      m_axis_tuser,
    output logic            m_axis_tlast
);

    logic           fr_valid;
    logic           fr_ready;
    t_elem          fr_elem;
    logic           en;
    logic           sq_valid;
    logic [NMW-1:0] sq_num [3];
    logic [DMW-1:0] sq_den;
    t_tag           sq_tag;
    logic           dv_valid;
    logic [NMW-1:0] dv_quo [3];
    t_tag           dv_tag;
    logic [CW-1:0]  grad [4];
    t_tag           out_tag;

    // divider and post stages move together, held only by a full output beat
    assign en = !m_axis_tvalid || m_axis_tready;

    tsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_elem  (fr_elem)
    );

    tsg_rowseq u_rowseq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_elem  (fr_elem),
        .i_en    (en),
        .o_valid (sq_valid),
        .o_num   (sq_num),
        .o_den   (sq_den),
        .o_tag   (sq_tag)
    );

    tsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   (sq_num),
        .i_den   (sq_den),
        .i_tag   (sq_tag),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    tsg_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_tag   (dv_tag),
        .o_valid (m_axis_tvalid),
        .o_grad  (grad),
        .o_tag   (out_tag)
    );

    assign m_axis_tdata = {grad[3], grad[2], grad[1], grad[0]};
    assign m_axis_tuser = {out_tag.degen, out_tag.axis};
    assign m_axis_tlast = out_tag.last;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case tetrahedra into tet_shape_gradient and checks
// every output beat against an exact wide-integer gradient computation.
// ----------------------------------------------------------------------------
module testbench;
    import tsg_pkg::*;

    typedef logic signed [31:0] t_crd;
    typedef struct {
        logic [1:0]  axis;
        logic [31:0] g[4];
        logic        degen;
        logic        last;
    } t_grad_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [4*CW-1:0] m_axis_tdata;
    logic [2:0]      m_axis_tuser;
    logic            m_axis_tlast;

    tet_shape_gradient uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [IN_W-1:0] elem_queue[$];
    t_grad_row       grad_rows[$];
    int              errors = 0;
    int              cycle = 0;
    bit              stim_done = 0;
    bit              calm = 0;        // stretch with no idling
    bit              sink_hold = 0;   // long receiver hold-off
    bit              src_pause = 0;   // sender waits for drain
    bit              in_taken = 0;    // input beat accepted at the last rising edge

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] sat_grad(input logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (v < -128'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    // exact cofactor inverse, three rows per element
    task automatic predict_gradients(input logic [IN_W-1:0] crd);
        logic signed [127:0] jac[3][3];
        logic signed [127:0] adj[3][3];
        logic signed [127:0] det, num, quo, sum;
        t_grad_row row;
        int r1, r2, c1, c2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                jac[i][j] = 128'(t_crd'(crd[(i*3+j)*32 +: 32]))
                          - 128'(t_crd'(crd[(9+j)*32 +: 32]));
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++) begin
                r1 = (k+1)%3; r2 = (k+2)%3; c1 = (j+1)%3; c2 = (j+2)%3;
                adj[j][k] = jac[r1][c1]*jac[r2][c2] - jac[r1][c2]*jac[r2][c1];
            end
        det = 0;
        for (int j = 0; j < 3; j++) det += jac[0][j] * adj[j][0];
        for (int j = 0; j < 3; j++) begin
            row.axis = 2'(j);
            row.degen = (det == 0);
            row.last = (j == 2);
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                if (det == 0) begin
                    quo = 0;
                end else begin
                    num = adj[j][k] <<< (2*FRAC_BITS);
                    quo = num / det;   // truncates toward zero
                end
                sum += quo;
                row.g[k] = sat_grad(quo);
            end
            row.g[3] = (det == 0) ? 32'h0 : sat_grad(-sum);
            grad_rows.insert(grad_rows.size(), row);
        end
    endtask

    function automatic t_crd rand_crd(input int mode);
        case (mode)
            0: return t_crd'($urandom);
            1: return t_crd'($urandom_range(0, 20) << 16) - (10 << 16);
            2: return t_crd'($urandom_range(0, 400000)) - 200000;
            default: return t_crd'(32'h80000000 ^ $urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [IN_W-1:0] tet(input t_crd v[12]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < 12; i++) d[i*32 +: 32] = v[i];
        return d;
    endfunction

    initial begin
        t_crd v[12];
        int mode;
        // unit tetrahedron: a=(1,0,0) b=(0,1,0) c=(0,0,1) d=origin
        v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0};
        elem_queue.insert(elem_queue.size(), tet(v));
        // all corners equal: degenerate
        foreach (v[i]) v[i] = 32'h12345678;
        elem_queue.insert(elem_queue.size(), tet(v));
        // coplanar corners
        v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 0, 0, 0};
        elem_queue.insert(elem_queue.size(), tet(v));
        // nearly flat: one lsb height, gradients saturate
        v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 1, 0, 0, 0};
        elem_queue.insert(elem_queue.size(), tet(v));
        v = '{-32'sh10000, 0, 0, 0, 32'h10000, 0, 0, 0, 1, 0, 0, 0};
        elem_queue.insert(elem_queue.size(), tet(v));
        // field extremes
        v = '{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF,
              32'h80000000, 32'h80000000, 32'h80000000};
        elem_queue.insert(elem_queue.size(), tet(v));
        v = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        elem_queue.insert(elem_queue.size(), tet(v));
        foreach (v[i]) v[i] = (i % 4 == 0) ? 32'hFFFFFFFF : 0;
        elem_queue.insert(elem_queue.size(), tet(v));
        // large element: tiny gradients
        v = '{32'h40000000, 0, 0, 0, 32'h40000000, 0, 0, 0, 32'h40000000, 0, 0, 0};
        elem_queue.insert(elem_queue.size(), tet(v));
        for (int n = 0; n < 6; n++) begin
            foreach (v[i]) v[i] = rand_crd(3);
            elem_queue.insert(elem_queue.size(), tet(v));
        end
        for (int n = 0; n < 165; n++) begin
            mode = $urandom_range(0, 9);
            foreach (v[i]) v[i] = rand_crd(mode < 3 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : 3);
            if ($urandom_range(0, 15) == 0) begin
                // repeated corner
                for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
            end
            elem_queue.insert(elem_queue.size(), tet(v));
        end
    end

    // sender side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (elem_queue.size() != 0 && !src_pause &&
                (calm || $urandom_range(0, 99) >= 9)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= elem_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
                if (elem_queue.size() == 0) stim_done <= 1'b1;
            end
        end
    end

    // receiver side
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !sink_hold && (calm || $urandom_range(0, 99) >= 9);
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) predict_gradients(s_axis_tdata);
    end

    // output check
    always @(posedge i_clk) begin
        t_grad_row exp_row;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (grad_rows.size() == 0) begin
                $display("%0t: unexpected beat tdata=%h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_row = grad_rows.pop_front();
                for (int k = 0; k < 4; k++)
                    if (m_axis_tdata[k*32 +: 32] !== exp_row.g[k]) begin
                        $display("%0t: grad[%0d] axis %0d expected %h actual %h", $time,
                                 k, exp_row.axis, exp_row.g[k], m_axis_tdata[k*32 +: 32]);
                        errors++;
                    end
                if (m_axis_tuser[1:0] !== exp_row.axis) begin
                    $display("%0t: axis expected %0d actual %0d", $time,
                             exp_row.axis, m_axis_tuser[1:0]);
                    errors++;
                end
                if (m_axis_tuser[2] !== exp_row.degen) begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             exp_row.degen, m_axis_tuser[2]);
                    errors++;
                end
                if (m_axis_tlast !== exp_row.last) begin
                    $display("%0t: tlast expected %b actual %b", $time,
                             exp_row.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // phases: pressure tests, a calm stretch, then random traffic until drained
    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        repeat (200) @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (600) @(posedge i_clk);
        sink_hold = 1'b0;
        src_pause = 1'b1;
        wait (grad_rows.size() == 0);
        @(posedge i_clk);
        src_pause = 1'b0;
        repeat (300) @(posedge i_clk);
        calm = 1'b1;
        repeat (400) @(posedge i_clk);
        calm = 1'b0;
        wait (stim_done && !s_axis_tvalid && grad_rows.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && grad_rows.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/tsg_pkg.sv
rtl/core/tsg_front.sv
rtl/core/tsg_rowseq.sv
rtl/core/tsg_div.sv
rtl/core/tsg_post.sv
rtl/core/tet_shape_gradient.sv
bench/testbench.sv
